// ===== src/r68_pkg.sv =====
// r68_pkg: constants and types shared by the code 68 float converter.
// No dependencies.
package r68_pkg;

    localparam logic [31:0] C68_ZERO    = 32'h4000_0000;
    localparam logic [31:0] C68_POS_SAT = 32'h7FFF_FFFF;
    localparam logic [31:0] C68_NEG_SAT = 32'hFFC0_0000;
    localparam logic        OP_DECODE   = 1'b0;
    localparam logic        OP_ENCODE   = 1'b1;

    // index of highest set bit of a 24-bit magnitude (0 when empty)
    function automatic logic [4:0] top_bit(input logic [23:0] a);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (a[i])
            begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

endpackage

// ===== src/r68_pipe.sv =====
// r68_pipe: three-stage conversion datapath with stall-aware valid bits.
// Depends on r68_pkg.
module r68_pipe
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        opcode,
    input  logic [63:0] operand,
    input  logic        adv,
    output logic        out_valid,
    output logic [63:0] out_data
);

    // stage 1: field split and decode magnitude
    logic        v1_reg, op1_reg, neg1_reg, spec1_reg;
    logic [31:0] spec_word1_reg;
    logic [23:0] mag1_reg;
    logic signed [9:0] ex1_reg;
    logic [52:0] sig1_reg;
    logic [5:0]  sh1_reg;

    // stage 2: normalise / shift
    logic        v2_reg, op2_reg, neg2_reg, spec2_reg;
    logic [31:0] spec_word2_reg;
    logic [23:0] mag2_reg;
    logic [4:0]  p2_reg;
    logic signed [9:0] ex2_reg;
    logic [22:0] sig2_reg;

    // stage 3: output
    logic        v3_reg;
    logic [63:0] res3_reg;

    logic        neg_in;
    logic [10:0] bexp;
    logic signed [11:0] exd;
    logic [23:0] mag_in;
    logic signed [9:0] ex_in;
    logic        spec_in;
    logic [31:0] spec_word_in;
    logic [5:0]  sh_in;
    logic [52:0] sig_sh;
    logic [10:0] biased;
    logic [52:0] mwide;
    logic [7:0]  efield;
    logic [22:0] mfield;
    logic [63:0] res_next;

    // stage 1 combinational
    always_comb
    begin
        bexp         = operand[62:52];
        exd          = 12'(signed'({1'b0, bexp})) - 12'sd1022;
        spec_in      = 1'b0;
        spec_word_in = r68_pkg::C68_ZERO;
        sh_in        = 6'd30;
        ex_in        = 10'(exd);
        if (opcode == r68_pkg::OP_DECODE)
        begin
            neg_in = operand[31];
            if (operand[31])
            begin
                mag_in = 24'h80_0000 - {1'b0, operand[22:0]};
                ex_in  = 10'sd104 - 10'(signed'({2'b0, operand[30:23]}));
            end
            else
            begin
                mag_in = {1'b0, operand[22:0]};
                ex_in  = 10'(signed'({2'b0, operand[30:23]})) - 10'sd151;
            end
        end
        else
        begin
            neg_in = operand[63];
            mag_in = '0;
            if (bexp == 11'h7FF)
            begin
                spec_in = 1'b1;
                if (operand[51:0] != '0)
                    spec_word_in = r68_pkg::C68_ZERO;
                else
                    spec_word_in = operand[63] ? r68_pkg::C68_NEG_SAT
                                               : r68_pkg::C68_POS_SAT;
            end
            else if (bexp == 11'd0 || exd <= -12'sd151)
            begin
                spec_in = 1'b1;
            end
            else if (exd > 12'sd127)
            begin
                spec_in      = 1'b1;
                spec_word_in = operand[63] ? r68_pkg::C68_NEG_SAT
                                           : r68_pkg::C68_POS_SAT;
            end
            else if (exd < -12'sd128)
            begin
                sh_in = 6'(12'sd30 - 12'sd128 - exd);
                ex_in = -10'sd128;
            end
        end
    end

    // stage 2 combinational shift of the encode significand
    assign sig_sh = sig1_reg >> sh1_reg;

    // stage 3 combinational assembly
    always_comb
    begin
        biased   = 11'(signed'({6'b0, p2_reg}) + 11'(ex2_reg) + 11'sd1023);
        mwide    = 53'(mag2_reg) << (6'd52 - 6'(p2_reg));
        efield   = neg2_reg ? 8'(10'sd127 - ex2_reg) : 8'(ex2_reg - 10'sd128);
        mfield   = neg2_reg ? 23'(-sig2_reg) : sig2_reg;
        if (op2_reg == r68_pkg::OP_DECODE)
        begin
            if (mag2_reg == '0)
                res_next = '0;
            else
                res_next = {neg2_reg, biased, mwide[51:0]};
        end
        else if (spec2_reg)
            res_next = {32'd0, spec_word2_reg};
        else
            res_next = {32'd0, neg2_reg, efield, mfield};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg        <= opcode;
            neg1_reg       <= neg_in;
            spec1_reg      <= spec_in;
            spec_word1_reg <= spec_word_in;
            mag1_reg       <= mag_in;
            ex1_reg        <= ex_in;
            sig1_reg       <= {1'b1, operand[51:0]};
            sh1_reg        <= sh_in;

            op2_reg        <= op1_reg;
            neg2_reg       <= neg1_reg;
            spec2_reg      <= spec1_reg;
            spec_word2_reg <= spec_word1_reg;
            mag2_reg       <= mag1_reg;
            p2_reg         <= r68_pkg::top_bit(mag1_reg);
            ex2_reg        <= ex1_reg;
            sig2_reg       <= sig_sh[22:0];

            res3_reg       <= res_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = res3_reg;

`ifndef SYNTHESIS
    // a bubble never turns into an item on a stall
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> v3_reg == $past(v3_reg))
        else $error("valid changed while stalled");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> v2_reg == $past(v1_reg))
        else $error("valid lost between stages");
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv && v3_reg) |=> $stable(res3_reg))
        else $error("result changed while stalled");
`endif

endmodule

// ===== src/rep68_float_converter.sv =====
// Throughput: one item per cycle; three register stages (split, normalise/
// shift, assemble) advance together, held whole when the result is not taken.
// Reset: rst_n asynchronous active low clears all stage valid bits.
// Top level of the code 68 / IEEE double converter; depends on r68_pkg, r68_pipe.
module rep68_float_converter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // operand[63:0]
    input  logic        s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // result[63:0]
);

    logic adv;

    // pipeline moves when output slot is free or being taken
    assign adv           = m_axis_tready || !m_axis_tvalid || 1'b0;
    assign s_axis_tready = adv;

    r68_pipe u_pipe
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .opcode    (s_axis_tuser),
        .operand   (s_axis_tdata),
        .adv       (adv),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

endmodule
